[hdl/sos_pkg.sv]
// sos_pkg: shared types, widths, register indexes and status codes of the
// sonar obstacle steering block; no dependencies
package sos_pkg;

   localparam int DIST_BITS_DEF = 13;

   localparam int LIM_W   = 13;
   localparam int SPEED_W = 12;
   localparam int QUAD_W  = 16;
   localparam int LIN_W   = 18;
   localparam int TURN_W  = 13;
   localparam int STAT_W  = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 18;

   // product scaling
   localparam int QUAD_SHIFT = 20;
   localparam int LIN_SHIFT  = 16;

   // saturation magnitudes
   localparam int TURN_POS_MAG = 4095;
   localparam int TURN_NEG_MAG = 4096;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_WARN   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LEFT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CENTRE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RIGHT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CRUISE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_QUAD   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_LIN    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_HEAD   = 3'd7;

   // register reset values
   localparam logic [LIM_W-1:0]         WARN_RST   = 13'd230;
   localparam logic [LIM_W-1:0]         LEFT_RST   = 13'd700;
   localparam logic [LIM_W-1:0]         CENTRE_RST = 13'd500;
   localparam logic [LIM_W-1:0]         RIGHT_RST  = 13'd700;
   localparam logic [SPEED_W-1:0]       CRUISE_RST = 12'd200;
   localparam logic [QUAD_W-1:0]        QUAD_RST   = 16'd5462;
   localparam logic [LIN_W-1:0]         LIN_RST    = 18'd45875;
   localparam logic signed [TURN_W-1:0] HEAD_RST   = -13'sd563;

   // status codes
   localparam logic [STAT_W-1:0] ST_STOP        = 4'd0;
   localparam logic [STAT_W-1:0] ST_LEFT_CENTRE = 4'd1;
   localparam logic [STAT_W-1:0] ST_CENTRE_RIGHT = 4'd2;
   localparam logic [STAT_W-1:0] ST_BOTH_SIDES  = 4'd3;
   localparam logic [STAT_W-1:0] ST_LEFT        = 4'd4;
   localparam logic [STAT_W-1:0] ST_RIGHT       = 4'd5;
   localparam logic [STAT_W-1:0] ST_CENTRE_TL   = 4'd6;
   localparam logic [STAT_W-1:0] ST_CENTRE_TR   = 4'd7;
   localparam logic [STAT_W-1:0] ST_CLEAR       = 4'd8;

   typedef struct packed {
      logic [LIM_W-1:0]         warn;
      logic [LIM_W-1:0]         left_lim;
      logic [LIM_W-1:0]         centre_lim;
      logic [LIM_W-1:0]         right_lim;
      logic [SPEED_W-1:0]       cruise;
      logic [QUAD_W-1:0]        quad;
      logic [LIN_W-1:0]         lin;
      logic signed [TURN_W-1:0] head;
   } cfg_type;

   // decision that travels with the distance through the turn pipeline
   typedef struct packed {
      logic [STAT_W-1:0]        status;
      logic [SPEED_W-1:0]       speed;
      logic                     use_quad;
      logic                     right_side;
      logic signed [TURN_W-1:0] turn_fix;
   } ctrl_type;

endpackage

[hdl/sos_csr.sv]
// sos_csr: configuration register file with write-only access
// depends on sos_pkg
module sos_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [sos_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sos_pkg::CSR_DATA_W-1:0]  csr_wr_data,
   output sos_pkg::cfg_type                cfg
);

   sos_pkg::cfg_type cfg_ff;
   sos_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            sos_pkg::REG_WARN:   cfg_in.warn       = csr_wr_data[sos_pkg::LIM_W-1:0];
            sos_pkg::REG_LEFT:   cfg_in.left_lim   = csr_wr_data[sos_pkg::LIM_W-1:0];
            sos_pkg::REG_CENTRE: cfg_in.centre_lim = csr_wr_data[sos_pkg::LIM_W-1:0];
            sos_pkg::REG_RIGHT:  cfg_in.right_lim  = csr_wr_data[sos_pkg::LIM_W-1:0];
            sos_pkg::REG_CRUISE: cfg_in.cruise     = csr_wr_data[sos_pkg::SPEED_W-1:0];
            sos_pkg::REG_QUAD:   cfg_in.quad       = csr_wr_data[sos_pkg::QUAD_W-1:0];
            sos_pkg::REG_LIN:    cfg_in.lin        = csr_wr_data[sos_pkg::LIN_W-1:0];
            sos_pkg::REG_HEAD:   cfg_in.head       = $signed(csr_wr_data[sos_pkg::TURN_W-1:0]);
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.warn       <= sos_pkg::WARN_RST;
         cfg_ff.left_lim   <= sos_pkg::LEFT_RST;
         cfg_ff.centre_lim <= sos_pkg::CENTRE_RST;
         cfg_ff.right_lim  <= sos_pkg::RIGHT_RST;
         cfg_ff.cruise     <= sos_pkg::CRUISE_RST;
         cfg_ff.quad       <= sos_pkg::QUAD_RST;
         cfg_ff.lin        <= sos_pkg::LIN_RST;
         cfg_ff.head       <= sos_pkg::HEAD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[hdl/sos_decide.sv]
// sos_decide: first pipeline stage, distance compares and case priority
// depends on sos_pkg
module sos_decide #(
   parameter int DIST_BITS = sos_pkg::DIST_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sos_pkg::cfg_type      cfg,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [DIST_BITS-1:0]  left_mm,
   input  logic [DIST_BITS-1:0]  centre_mm,
   input  logic [DIST_BITS-1:0]  right_mm,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [DIST_BITS-1:0]  out_dist,
   output sos_pkg::ctrl_type     out_ctrl
);

   localparam int CMP_W = (DIST_BITS > sos_pkg::LIM_W) ? DIST_BITS : sos_pkg::LIM_W;

   logic [CMP_W-1:0] l_x, c_x, r_x, warn_x, llim_x, clim_x, rlim_x;
   logic             warn_hit, lc, cc, rc;

   sos_pkg::ctrl_type    ctrl_c;
   logic [DIST_BITS-1:0] dist_c;

   logic                 valid_ff, valid_in;
   logic [DIST_BITS-1:0] dist_ff, dist_in;
   sos_pkg::ctrl_type    ctrl_ff, ctrl_in;

   assign l_x    = CMP_W'(left_mm);
   assign c_x    = CMP_W'(centre_mm);
   assign r_x    = CMP_W'(right_mm);
   assign warn_x = CMP_W'(cfg.warn);
   assign llim_x = CMP_W'(cfg.left_lim);
   assign clim_x = CMP_W'(cfg.centre_lim);
   assign rlim_x = CMP_W'(cfg.right_lim);

   assign warn_hit = (l_x <= warn_x) || (c_x <= warn_x) || (r_x <= warn_x);
   assign lc = (l_x <= llim_x);
   assign cc = (c_x <= clim_x);
   assign rc = (r_x <= rlim_x);

   always_comb begin
      ctrl_c.status     = sos_pkg::ST_CLEAR;
      ctrl_c.speed      = cfg.cruise;
      ctrl_c.use_quad   = 1'b0;
      ctrl_c.right_side = 1'b0;
      ctrl_c.turn_fix   = '0;
      dist_c            = left_mm;
      if (warn_hit) begin
         ctrl_c.status = sos_pkg::ST_STOP;
         ctrl_c.speed  = '0;
      end else if (lc && cc) begin
         ctrl_c.status   = sos_pkg::ST_LEFT_CENTRE;
         ctrl_c.use_quad = 1'b1;
      end else if (cc && rc) begin
         ctrl_c.status     = sos_pkg::ST_CENTRE_RIGHT;
         ctrl_c.use_quad   = 1'b1;
         ctrl_c.right_side = 1'b1;
         dist_c            = right_mm;
      end else if (lc && rc) begin
         ctrl_c.status = sos_pkg::ST_BOTH_SIDES;
         ctrl_c.speed  = {1'b0, cfg.cruise[sos_pkg::SPEED_W-1:1]};
      end else if (lc) begin
         ctrl_c.status   = sos_pkg::ST_LEFT;
         ctrl_c.use_quad = 1'b1;
      end else if (rc) begin
         ctrl_c.status     = sos_pkg::ST_RIGHT;
         ctrl_c.use_quad   = 1'b1;
         ctrl_c.right_side = 1'b1;
         dist_c            = right_mm;
      end else if (cc) begin
         if (l_x > r_x) begin
            ctrl_c.status     = sos_pkg::ST_CENTRE_TL;
            ctrl_c.use_quad   = 1'b1;
            ctrl_c.right_side = 1'b1;
            dist_c            = right_mm;
         end else if (l_x < r_x) begin
            ctrl_c.status   = sos_pkg::ST_CENTRE_TR;
            ctrl_c.use_quad = 1'b1;
         end else begin
            // head-on: sides equal, fixed turn
            ctrl_c.status   = sos_pkg::ST_CENTRE_TL;
            ctrl_c.turn_fix = cfg.head;
         end
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = in_ready ? in_valid : valid_ff;
      dist_in  = dist_ff;
      ctrl_in  = ctrl_ff;
      if (in_ready && in_valid) begin
         dist_in = dist_c;
         ctrl_in = ctrl_c;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dist_ff <= dist_in;
      ctrl_ff <= ctrl_in;
   end

   assign out_valid = valid_ff;
   assign out_dist  = dist_ff;
   assign out_ctrl  = ctrl_ff;

endmodule

[hdl/sos_turn.sv]
// sos_turn: three stage steering quadratic (two multiply stages, then sum,
// saturate and select into the output register); depends on sos_pkg
module sos_turn #(
   parameter int DIST_BITS = sos_pkg::DIST_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  sos_pkg::cfg_type                    cfg,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic [DIST_BITS-1:0]                in_dist,
   input  sos_pkg::ctrl_type                   in_ctrl,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic [sos_pkg::STAT_W-1:0]          out_status,
   output logic [sos_pkg::SPEED_W-1:0]         out_speed,
   output logic signed [sos_pkg::TURN_W-1:0]   out_turn_rate
);

   localparam int QD_W  = sos_pkg::QUAD_W + DIST_BITS;
   localparam int LD_W  = sos_pkg::LIN_W + DIST_BITS;
   localparam int QDD_W = sos_pkg::QUAD_W + 2 * DIST_BITS;
   localparam int LS_W  = LD_W - sos_pkg::LIN_SHIFT;
   localparam int QS_W  = QDD_W - sos_pkg::QUAD_SHIFT;
   // quadratic term is the wider one over the whole distance range
   localparam int MAG_W = QS_W + 1;

   logic ready2, ready3, ready4;

   // stage 2: quad*d and lin*d
   logic                 s2_valid_ff, s2_valid_in;
   logic [QD_W-1:0]      s2_qd_ff, s2_qd_in;
   logic [LD_W-1:0]      s2_ld_ff, s2_ld_in;
   logic [DIST_BITS-1:0] s2_dist_ff, s2_dist_in;
   sos_pkg::ctrl_type    s2_ctrl_ff, s2_ctrl_in;

   // stage 3: quad*d*d and scaled linear term
   logic                 s3_valid_ff, s3_valid_in;
   logic [QDD_W-1:0]     s3_qdd_ff, s3_qdd_in;
   logic [LS_W-1:0]      s3_ls_ff, s3_ls_in;
   sos_pkg::ctrl_type    s3_ctrl_ff, s3_ctrl_in;

   // stage 4: output register
   logic                               s4_valid_ff, s4_valid_in;
   logic [sos_pkg::STAT_W-1:0]         s4_status_ff, s4_status_in;
   logic [sos_pkg::SPEED_W-1:0]        s4_speed_ff, s4_speed_in;
   logic signed [sos_pkg::TURN_W-1:0]  s4_turn_ff, s4_turn_in;

   logic [MAG_W-1:0]                   mag;
   logic signed [sos_pkg::TURN_W-1:0]  turn_c;

   assign ready4   = !s4_valid_ff || out_ready;
   assign ready3   = !s3_valid_ff || ready4;
   assign ready2   = !s2_valid_ff || ready3;
   assign in_ready = ready2;

   always_comb begin
      s2_valid_in = ready2 ? in_valid : s2_valid_ff;
      s2_qd_in    = s2_qd_ff;
      s2_ld_in    = s2_ld_ff;
      s2_dist_in  = s2_dist_ff;
      s2_ctrl_in  = s2_ctrl_ff;
      if (ready2 && in_valid) begin
         s2_qd_in   = QD_W'(cfg.quad) * QD_W'(in_dist);
         s2_ld_in   = LD_W'(cfg.lin) * LD_W'(in_dist);
         s2_dist_in = in_dist;
         s2_ctrl_in = in_ctrl;
      end
   end

   always_comb begin
      s3_valid_in = ready3 ? s2_valid_ff : s3_valid_ff;
      s3_qdd_in   = s3_qdd_ff;
      s3_ls_in    = s3_ls_ff;
      s3_ctrl_in  = s3_ctrl_ff;
      if (ready3 && s2_valid_ff) begin
         s3_qdd_in  = QDD_W'(s2_qd_ff) * QDD_W'(s2_dist_ff);
         s3_ls_in   = s2_ld_ff[LD_W-1:sos_pkg::LIN_SHIFT];
         s3_ctrl_in = s2_ctrl_ff;
      end
   end

   assign mag = MAG_W'(s3_qdd_ff[QDD_W-1:sos_pkg::QUAD_SHIFT]) + MAG_W'(s3_ls_ff);

   always_comb begin
      turn_c = s3_ctrl_ff.turn_fix;
      if (s3_ctrl_ff.use_quad) begin
         if (s3_ctrl_ff.right_side) begin
            // right side: positive, clamp at top of range
            if (mag > MAG_W'(sos_pkg::TURN_POS_MAG)) begin
               turn_c = sos_pkg::TURN_W'(sos_pkg::TURN_POS_MAG);
            end else begin
               turn_c = $signed(mag[sos_pkg::TURN_W-1:0]);
            end
         end else begin
            // left side: negative, clamp at bottom of range
            if (mag >= MAG_W'(sos_pkg::TURN_NEG_MAG)) begin
               turn_c = -sos_pkg::TURN_W'(sos_pkg::TURN_NEG_MAG);
            end else begin
               turn_c = -$signed(mag[sos_pkg::TURN_W-1:0]);
            end
         end
      end
   end

   always_comb begin
      s4_valid_in  = ready4 ? s3_valid_ff : s4_valid_ff;
      s4_status_in = s4_status_ff;
      s4_speed_in  = s4_speed_ff;
      s4_turn_in   = s4_turn_ff;
      if (ready4 && s3_valid_ff) begin
         s4_status_in = s3_ctrl_ff.status;
         s4_speed_in  = s3_ctrl_ff.speed;
         s4_turn_in   = turn_c;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_qd_ff     <= s2_qd_in;
      s2_ld_ff     <= s2_ld_in;
      s2_dist_ff   <= s2_dist_in;
      s2_ctrl_ff   <= s2_ctrl_in;
      s3_qdd_ff    <= s3_qdd_in;
      s3_ls_ff     <= s3_ls_in;
      s3_ctrl_ff   <= s3_ctrl_in;
      s4_status_ff <= s4_status_in;
      s4_speed_ff  <= s4_speed_in;
      s4_turn_ff   <= s4_turn_in;
   end

   assign out_valid     = s4_valid_ff;
   assign out_status    = s4_status_ff;
   assign out_speed     = s4_speed_ff;
   assign out_turn_rate = s4_turn_ff;

endmodule

[hdl/sonar_obstacle_steering_top.sv]
// sonar_obstacle_steering_top: steering decision from three sonar distances
// depends on sos_pkg, sos_csr, sos_decide, sos_turn
//
//   channel | ports                                        | direction
//   --------+----------------------------------------------+----------
//   req     | req_valid/req_ready, left/centre/right_mm    | in
//   rsp     | rsp_valid/rsp_ready, status, speed, turn_rate| out
//   csr     | csr_wr_en, csr_index, csr_wr_data            | in
//
// one transfer per cycle sustained while rsp_ready stays high; four register
// stages (decide, two multiplies, sum and saturate into the output
// register): a reading is registered in each stage in turn before
// rsp_valid rises for it
// synchronous active-high reset clears the valid bits and loads the
// register defaults; a stall on rsp holds each full stage, and empty
// stages still fill, so req_ready stays high until the pipeline is full
module sonar_obstacle_steering_top #(
   parameter int DIST_BITS = sos_pkg::DIST_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // input channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [DIST_BITS-1:0]                req_left_mm,
   input  logic [DIST_BITS-1:0]                req_centre_mm,
   input  logic [DIST_BITS-1:0]                req_right_mm,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [sos_pkg::STAT_W-1:0]          rsp_status,
   output logic [sos_pkg::SPEED_W-1:0]         rsp_speed,
   output logic signed [sos_pkg::TURN_W-1:0]   rsp_turn_rate,
   // configuration writes
   input  logic                                csr_wr_en,
   input  logic [sos_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sos_pkg::CSR_DATA_W-1:0]      csr_wr_data
);

   sos_pkg::cfg_type     cfg;

   // decide stage to turn pipeline
   logic                 dec_valid;
   logic                 dec_ready;
   logic [DIST_BITS-1:0] dec_dist;
   sos_pkg::ctrl_type    dec_ctrl;

   // register file; write it only while the pipeline is idle (the block does not enforce this)
   sos_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   // stage 1: warn check, limit compares, case priority, side select
   sos_decide #(
      .DIST_BITS (DIST_BITS)
   ) u_decide (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .left_mm   (req_left_mm),
      .centre_mm (req_centre_mm),
      .right_mm  (req_right_mm),
      .out_valid (dec_valid),
      .out_ready (dec_ready),
      .out_dist  (dec_dist),
      .out_ctrl  (dec_ctrl)
   );

   // stages 2 to 4: quadratic of the selected side, saturation, output register
   sos_turn #(
      .DIST_BITS (DIST_BITS)
   ) u_turn (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .in_valid      (dec_valid),
      .in_ready      (dec_ready),
      .in_dist       (dec_dist),
      .in_ctrl       (dec_ctrl),
      .out_valid     (rsp_valid),
      .out_ready     (rsp_ready),
      .out_status    (rsp_status),
      .out_speed     (rsp_speed),
      .out_turn_rate (rsp_turn_rate)
   );

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// tb_top: self-checking testbench for sonar_obstacle_steering_top
// depends on sos_pkg and the block's RTL; predicts each steering command
// from a shadow copy of the registers and checks every rsp transfer in order
module tb_top;

   localparam int DIST_W   = sos_pkg::DIST_BITS_DEF;
   localparam int DIST_MAX = (1 << DIST_W) - 1;

   // one sonar reading (req payload) and one steering command (rsp payload)
   typedef struct packed {
      logic [DIST_W-1:0] left_mm;
      logic [DIST_W-1:0] centre_mm;
      logic [DIST_W-1:0] right_mm;
   } sonar_read_type;

   typedef struct packed {
      logic [sos_pkg::STAT_W-1:0]        status;
      logic [sos_pkg::SPEED_W-1:0]       speed;
      logic signed [sos_pkg::TURN_W-1:0] turn_rate;
   } steer_cmd_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                               req_valid     = 1'b0;
   logic                               req_ready;
   logic [DIST_W-1:0]                  req_left_mm   = '0;
   logic [DIST_W-1:0]                  req_centre_mm = '0;
   logic [DIST_W-1:0]                  req_right_mm  = '0;
   logic                               rsp_valid;
   logic                               rsp_ready     = 1'b0;
   logic [sos_pkg::STAT_W-1:0]         rsp_status;
   logic [sos_pkg::SPEED_W-1:0]        rsp_speed;
   logic signed [sos_pkg::TURN_W-1:0]  rsp_turn_rate;
   logic                               csr_wr_en     = 1'b0;
   logic [sos_pkg::CSR_IDX_W-1:0]      csr_index     = '0;
   logic [sos_pkg::CSR_DATA_W-1:0]     csr_wr_data   = '0;

   // readings waiting to be sent, and commands owed by the block, oldest first
   sonar_read_type pending_reads[$];
   steer_cmd_type  owed_cmds[$];

   // shadow of the block's registers, kept in step with every csr write
   sos_pkg::cfg_type cfg_shadow;

   sonar_read_type on_wire;       // reading currently offered on req
   steer_cmd_type  seen_due;      // expectation popped for the current rsp transfer
   int             send_gap  = 0;
   int             hold_gap  = 0;
   int             mismatch_count = 0;
   bit             idle_on   = 1'b1;   // random idling on both channels

   sonar_obstacle_steering_top uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_left_mm   (req_left_mm),
      .req_centre_mm (req_centre_mm),
      .req_right_mm  (req_right_mm),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_speed     (rsp_speed),
      .rsp_turn_rate (rsp_turn_rate),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // steering prediction
   // ---------------------------------------------------------------------

   // magnitude of the steering quadratic: square term plus linear term,
   // each truncated by its own shift before the sum
   function automatic logic [63:0] steer_mag(input logic [DIST_W-1:0] d,
                                             input sos_pkg::cfg_type k);
      logic [63:0] sq_term;
      logic [63:0] lin_term;
      sq_term  = (64'(k.quad) * 64'(d) * 64'(d)) >> sos_pkg::QUAD_SHIFT;
      lin_term = (64'(k.lin) * 64'(d)) >> sos_pkg::LIN_SHIFT;
      return sq_term + lin_term;
   endfunction

   // left-side obstacle: turn right (negative), clipped at the most negative code
   function automatic logic signed [sos_pkg::TURN_W-1:0] left_side_turn(
      input logic [DIST_W-1:0] d, input sos_pkg::cfg_type k);
      logic [63:0] m;
      m = steer_mag(d, k);
      if (m > sos_pkg::TURN_NEG_MAG) m = sos_pkg::TURN_NEG_MAG;
      return sos_pkg::TURN_W'(64'd0 - m);
   endfunction

   // right-side obstacle: turn left (positive), clipped at the most positive code
   function automatic logic signed [sos_pkg::TURN_W-1:0] right_side_turn(
      input logic [DIST_W-1:0] d, input sos_pkg::cfg_type k);
      logic [63:0] m;
      m = steer_mag(d, k);
      if (m > sos_pkg::TURN_POS_MAG) m = sos_pkg::TURN_POS_MAG;
      return sos_pkg::TURN_W'(m);
   endfunction

   function automatic steer_cmd_type predict_steering(input sonar_read_type s,
                                                      input sos_pkg::cfg_type k);
      steer_cmd_type cmd;
      logic near_l;
      logic near_c;
      logic near_r;
      near_l = s.left_mm   <= k.left_lim;
      near_c = s.centre_mm <= k.centre_lim;
      near_r = s.right_mm  <= k.right_lim;
      cmd.status    = sos_pkg::ST_CLEAR;
      cmd.speed     = k.cruise;
      cmd.turn_rate = '0;
      // any sensor inside the warn range overrides everything else
      if (s.left_mm <= k.warn || s.centre_mm <= k.warn || s.right_mm <= k.warn) begin
         cmd.status = sos_pkg::ST_STOP;
         cmd.speed  = '0;
      end else if (near_l && near_c) begin
         cmd.status    = sos_pkg::ST_LEFT_CENTRE;
         cmd.turn_rate = left_side_turn(s.left_mm, k);
      end else if (near_c && near_r) begin
         cmd.status    = sos_pkg::ST_CENTRE_RIGHT;
         cmd.turn_rate = right_side_turn(s.right_mm, k);
      end else if (near_l && near_r) begin
         // squeezed from both sides: straight ahead at half speed
         cmd.status = sos_pkg::ST_BOTH_SIDES;
         cmd.speed  = k.cruise >> 1;
      end else if (near_l) begin
         cmd.status    = sos_pkg::ST_LEFT;
         cmd.turn_rate = left_side_turn(s.left_mm, k);
      end else if (near_r) begin
         cmd.status    = sos_pkg::ST_RIGHT;
         cmd.turn_rate = right_side_turn(s.right_mm, k);
      end else if (near_c) begin
         // centre only: steer away from the nearer side, fixed turn on a tie
         if (s.left_mm > s.right_mm) begin
            cmd.status    = sos_pkg::ST_CENTRE_TL;
            cmd.turn_rate = right_side_turn(s.right_mm, k);
         end else if (s.left_mm < s.right_mm) begin
            cmd.status    = sos_pkg::ST_CENTRE_TR;
            cmd.turn_rate = left_side_turn(s.left_mm, k);
         end else begin
            cmd.status    = sos_pkg::ST_CENTRE_TL;
            cmd.turn_rate = k.head;
         end
      end
      return cmd;
   endfunction

   // ---------------------------------------------------------------------
   // req driver: offers queued readings, predicts at each accepted transfer
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready)
            owed_cmds.push_back(predict_steering(on_wire, cfg_shadow));
         if (req_valid && !req_ready) begin
            // offer stands until taken, payload untouched
         end else if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_reads.size() > 0) begin
            on_wire = pending_reads.pop_front();
            req_valid     <= 1'b1;
            req_left_mm   <= on_wire.left_mm;
            req_centre_mm <= on_wire.centre_mm;
            req_right_mm  <= on_wire.right_mm;
            // idle burst after this transfer, now and then
            if (idle_on && $urandom_range(0, 9) == 0)
               send_gap = $urandom_range(1, 17);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // rsp monitor: random stalls, in-order field compare
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_gap = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (owed_cmds.size() == 0) begin
               $error("unexpected rsp transfer: status %0d speed %0d turn_rate %0d",
                      rsp_status, rsp_speed, rsp_turn_rate);
               mismatch_count++;
            end else begin
               seen_due = owed_cmds.pop_front();
               if (rsp_status !== seen_due.status) begin
                  $error("status: expected %0d, got %0d", seen_due.status, rsp_status);
                  mismatch_count++;
               end
               if (rsp_speed !== seen_due.speed) begin
                  $error("speed: expected %0d, got %0d", seen_due.speed, rsp_speed);
                  mismatch_count++;
               end
               if (rsp_turn_rate !== seen_due.turn_rate) begin
                  $error("turn_rate: expected %0d, got %0d",
                         seen_due.turn_rate, rsp_turn_rate);
                  mismatch_count++;
               end
            end
         end
         if (hold_gap > 0) begin
            hold_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (idle_on && $urandom_range(0, 11) == 0)
               hold_gap = $urandom_range(1, 17);
         end
      end
   end

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------

   // one register write; unused upper data bits carry junk to check masking
   task automatic csr_put(input logic [sos_pkg::CSR_IDX_W-1:0] idx, input int value);
      logic [sos_pkg::CSR_DATA_W-1:0] data;
      data = sos_pkg::CSR_DATA_W'($urandom());
      case (idx)
         sos_pkg::REG_CRUISE: data[sos_pkg::SPEED_W-1:0] = sos_pkg::SPEED_W'(value);
         sos_pkg::REG_QUAD:   data[sos_pkg::QUAD_W-1:0]  = sos_pkg::QUAD_W'(value);
         sos_pkg::REG_LIN:    data                       = sos_pkg::LIN_W'(value);
         default:             data[sos_pkg::LIM_W-1:0]   = sos_pkg::LIM_W'(value);
      endcase
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      case (idx)
         sos_pkg::REG_WARN:   cfg_shadow.warn       = data[sos_pkg::LIM_W-1:0];
         sos_pkg::REG_LEFT:   cfg_shadow.left_lim   = data[sos_pkg::LIM_W-1:0];
         sos_pkg::REG_CENTRE: cfg_shadow.centre_lim = data[sos_pkg::LIM_W-1:0];
         sos_pkg::REG_RIGHT:  cfg_shadow.right_lim  = data[sos_pkg::LIM_W-1:0];
         sos_pkg::REG_CRUISE: cfg_shadow.cruise     = data[sos_pkg::SPEED_W-1:0];
         sos_pkg::REG_QUAD:   cfg_shadow.quad       = data[sos_pkg::QUAD_W-1:0];
         sos_pkg::REG_LIN:    cfg_shadow.lin        = data[sos_pkg::LIN_W-1:0];
         default:             cfg_shadow.head       = data[sos_pkg::TURN_W-1:0];
      endcase
   endtask

   task automatic apply_settings(input int warn, input int l_lim, input int c_lim,
                                 input int r_lim, input int cruise, input int quad,
                                 input int lin, input int head);
      csr_put(sos_pkg::REG_WARN, warn);
      csr_put(sos_pkg::REG_LEFT, l_lim);
      csr_put(sos_pkg::REG_CENTRE, c_lim);
      csr_put(sos_pkg::REG_RIGHT, r_lim);
      csr_put(sos_pkg::REG_CRUISE, cruise);
      csr_put(sos_pkg::REG_QUAD, quad);
      csr_put(sos_pkg::REG_LIN, lin);
      csr_put(sos_pkg::REG_HEAD, head);
   endtask

   task automatic queue_read(input int l, input int c, input int r);
      sonar_read_type s;
      s.left_mm   = DIST_W'(l);
      s.centre_mm = DIST_W'(c);
      s.right_mm  = DIST_W'(r);
      pending_reads.push_back(s);
   endtask

   // distance aimed at the decision boundaries of the current settings
   function automatic int pick_dist(input int lim);
      int warn;
      int above;
      warn  = cfg_shadow.warn;
      above = (warn + 1 > DIST_MAX) ? DIST_MAX : warn + 1;
      case ($urandom_range(0, 11))
         0:       return $urandom_range(0, warn);
         1:       return above;
         2, 3:    return $urandom_range(above, lim);
         4:       return lim;
         5:       return (lim + 1 > DIST_MAX) ? DIST_MAX : lim + 1;
         6, 7:    return $urandom_range(lim, DIST_MAX);
         8:       return $urandom_range(0, DIST_MAX);
         9:       return DIST_MAX;
         default: return $urandom_range(lim, (lim + 300 > DIST_MAX) ? DIST_MAX : lim + 300);
      endcase
   endfunction

   task automatic queue_random_reads(input int n);
      int l;
      int c;
      int r;
      repeat (n) begin
         l = pick_dist(cfg_shadow.left_lim);
         c = pick_dist(cfg_shadow.centre_lim);
         // ties between the sides are the head-on case, so make them common
         r = ($urandom_range(0, 7) == 0) ? l : pick_dist(cfg_shadow.right_lim);
         queue_read(l, c, r);
      end
   endtask

   // sampled at the falling edge, clear of the clocked blocks
   task automatic wait_drained;
      do @(negedge clock);
      while (pending_reads.size() != 0 || req_valid || owed_cmds.size() != 0);
   endtask

   task automatic random_settings;
      apply_settings($urandom_range(0, 1200), $urandom_range(0, 4000),
                     $urandom_range(0, 4000), $urandom_range(0, 4000),
                     $urandom_range(0, 4095),
                     $urandom_range(0, 1) ? $urandom_range(0, 8000) : $urandom_range(0, 65535),
                     $urandom_range(0, 1) ? $urandom_range(0, 60000) : $urandom_range(0, 262143),
                     $urandom_range(0, 8191));
   endtask

   // ---------------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------------
   initial begin
      cfg_shadow.warn       = sos_pkg::WARN_RST;
      cfg_shadow.left_lim   = sos_pkg::LEFT_RST;
      cfg_shadow.centre_lim = sos_pkg::CENTRE_RST;
      cfg_shadow.right_lim  = sos_pkg::RIGHT_RST;
      cfg_shadow.cruise     = sos_pkg::CRUISE_RST;
      cfg_shadow.quad       = sos_pkg::QUAD_RST;
      cfg_shadow.lin        = sos_pkg::LIN_RST;
      cfg_shadow.head       = sos_pkg::HEAD_RST;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed readings against the reset settings
      queue_read(230, 1000, 1000);      // stop, left at warn
      queue_read(1000, 230, 1000);      // stop, centre
      queue_read(1000, 1000, 230);      // stop, right
      queue_read(0, 0, 0);
      queue_read(231, 231, 231);        // just past warn: left and centre
      queue_read(600, 400, 1000);       // left and centre
      queue_read(1000, 400, 600);       // centre and right
      queue_read(600, 1000, 600);       // both sides, half speed
      queue_read(700, 501, 8191);       // left only, on its limit
      queue_read(8191, 8191, 700);      // right only
      queue_read(1000, 400, 900);       // centre, right side nearer
      queue_read(900, 400, 1000);       // centre, left side nearer
      queue_read(900, 400, 900);        // centre, sides equal: fixed turn
      queue_read(8191, 8191, 8191);     // clear
      queue_read(701, 501, 701);        // clear, one past every limit
      queue_read(5461, 2730, 5461);     // alternating bit patterns
      queue_read(2730, 5461, 2730);
      wait_drained();
      queue_random_reads(100);
      wait_drained();

      // everything at its minimum
      apply_settings(0, 0, 0, 0, 0, 0, 0, -4096);
      queue_read(0, 0, 0);
      queue_read(1, 1, 1);
      queue_read(DIST_MAX, 0, DIST_MAX);
      queue_random_reads(60);
      wait_drained();

      // warn at full range: every reading is a stop
      apply_settings(DIST_MAX, DIST_MAX, DIST_MAX, DIST_MAX, 4095, 65535, 262143, 4095);
      queue_random_reads(30);
      wait_drained();

      // all sensors near, largest coefficients: negative (right) turn saturates
      apply_settings(0, DIST_MAX, DIST_MAX, DIST_MAX, 4095, 65535, 262143, 4095);
      queue_read(DIST_MAX, DIST_MAX, DIST_MAX);
      queue_read(1, 1, 1);
      queue_random_reads(60);
      wait_drained();

      // tight left limit: centre and right case with saturated left turn
      apply_settings(0, 100, DIST_MAX, DIST_MAX, 4095, 65535, 262143, -4096);
      queue_read(DIST_MAX, DIST_MAX, DIST_MAX);
      queue_random_reads(60);
      wait_drained();

      repeat (7) begin
         random_settings();
         queue_random_reads(100);
         wait_drained();
      end

      // closing stretch at full rate on both channels
      idle_on = 1'b0;
      random_settings();
      queue_random_reads(100);
      wait_drained();

      // let any stray result show up
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // watchdog, several times the slowest legal run
   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

[sonar_obstacle_steering_top.f]
hdl/sos_pkg.sv
hdl/sos_csr.sv
hdl/sos_decide.sv
hdl/sos_turn.sv
hdl/sonar_obstacle_steering_top.sv
tb/tb_top.sv
